// ===== hw/rtl/owpm_pkg.sv =====
// ----------------------------------------------------------------------------
// owpm_pkg
// Shared types and constants of the oil paint window mode block.
// ----------------------------------------------------------------------------
package owpm_pkg;

  localparam int BUCKET_W = 8;
  localparam int BUCKETS = 256;
  localparam int CNT_W = 7;
  localparam int SUM_W = 15;
  localparam int CH_W = 8;
  localparam int NUM_W = 16;
  localparam int DIV_STEPS = NUM_W;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = 7'd127;
  localparam logic [7:0] SMOOTH_RESET = 8'd30;
  localparam logic [0:0] REG_SMOOTHNESS = 1'b0;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic [7:0] luma_in;
    logic       last_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic [7:0] winning_bucket;
    logic [6:0] winning_count;
  } out_item_t;

  // Classified pixel handed from the front to the back.
  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [3:0][CH_W-1:0] chan;
    logic                 last;
  } pix_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_UPDATE,
    B_SCAN,
    B_FETCH,
    B_LOAD,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

// ===== hw/rtl/owpm_front.sv =====
// ----------------------------------------------------------------------------
// owpm_front
// Accepts pixels, computes the intensity bucket and queues classified pixels.
// ----------------------------------------------------------------------------
module owpm_front #(
  parameter int QUEUE_DEPTH = owpm_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          smoothness,
  input  logic                in_push,
  output logic                in_full,
  input  owpm_pkg::in_item_t  in_data,
  input  logic                q_pop,
  output logic                q_empty,
  output owpm_pkg::pix_item_t q_item
);
  import owpm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  pix_item_t            entry_r [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]          fill_r, fill_nxt;
  logic [15:0]          prod;
  logic [23:0]          approx;
  logic [7:0]           q0;
  logic [16:0]          rem;
  logic [BUCKET_W-1:0]  bucket;
  pix_item_t            new_item;
  logic                 do_push, do_pop;

  // Bucket = floor(luma * smoothness / 255): reciprocal estimate, then one correction.
  always_comb begin
    prod   = 16'(in_data.luma_in) * 16'(smoothness);
    approx = 24'(prod) * 24'd257;
    q0     = approx[23:16];
    rem    = 17'(prod) - (17'({q0, 8'b0}) - 17'(q0));
    bucket = (rem >= 17'd255) ? q0 + 8'd1 : q0;
  end

  always_comb begin
    new_item.bucket  = bucket;
    new_item.chan[3] = in_data.red_in;
    new_item.chan[2] = in_data.green_in;
    new_item.chan[1] = in_data.blue_in;
    new_item.chan[0] = in_data.alpha_in;
    new_item.last    = in_data.last_pixel;
  end

  // Queue pointers and fill level.
  assign in_full = (fill_r == (PW+1)'(QUEUE_DEPTH));
  assign q_empty = (fill_r == '0);
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// ===== hw/rtl/owpm_back.sv =====
// ----------------------------------------------------------------------------
// owpm_back
// Histogram accumulation, winner scan, rounded division and result register.
// ----------------------------------------------------------------------------
module owpm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  owpm_pkg::pix_item_t q_item,
  output logic                out_empty,
  input  logic                out_pop,
  output owpm_pkg::out_item_t out_data
);
  import owpm_pkg::*;

  // Count and channel sum memories, one entry per bucket.
  logic [CNT_W-1:0]          cnt_mem [BUCKETS];
  logic [3:0][SUM_W-1:0]     sum_mem [BUCKETS];
  logic [BUCKETS-1:0]        valid_r;

  back_state_t               state_r, state_nxt;
  pix_item_t                 item_r;
  logic [BUCKET_W-1:0]       rd_addr;
  logic [CNT_W-1:0]          rd_cnt_r;
  logic [3:0][SUM_W-1:0]     rd_sum_r;
  logic                      rd_vld_r;
  logic                      wr_en;
  logic [CNT_W-1:0]          wr_cnt;
  logic [3:0][SUM_W-1:0]     wr_sum;
  logic [CNT_W-1:0]          cur_cnt;
  logic [BUCKET_W:0]         scan_ctr_r;
  logic                      cmp_en_r;
  logic [BUCKET_W-1:0]       cmp_addr_r;
  logic [BUCKET_W-1:0]       best_r;
  logic [CNT_W-1:0]          best_cnt_r;
  logic [CNT_W-1:0]          eff_cnt;
  logic [4:0]                step_r;
  logic [3:0][CNT_W-1:0]     rem_r;
  logic [3:0][NUM_W-1:0]     quo_r;
  logic                      out_valid_r;
  out_item_t                 out_r;
  logic [3:0][CH_W-1:0]      avg;

  assign cur_cnt = rd_vld_r ? rd_cnt_r : '0;
  assign eff_cnt = rd_vld_r ? rd_cnt_r : '0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:   if (!q_empty) state_nxt = B_UPDATE;
      B_UPDATE: state_nxt = item_r.last ? B_SCAN : B_IDLE;
      B_SCAN:   if (scan_ctr_r == (BUCKET_W+1)'(BUCKETS)) state_nxt = B_FETCH;
      B_FETCH:  state_nxt = B_LOAD;
      B_LOAD:   state_nxt = B_DIV;
      B_DIV:    if (step_r == 5'(DIV_STEPS-1)) state_nxt = B_OUT;
      B_OUT:    if (!out_valid_r) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop, read address and memory write.
  always_comb begin
    q_pop   = 1'b0;
    rd_addr = best_r;
    wr_en   = 1'b0;
    wr_cnt  = cur_cnt;
    wr_sum  = rd_sum_r;
    case (state_r)
      B_IDLE: begin
        q_pop   = !q_empty;
        rd_addr = q_item.bucket;
      end
      B_UPDATE: begin
        if (cur_cnt == '0) begin
          wr_en  = 1'b1;
          wr_cnt = CNT_W'(1);
          for (int c = 0; c < 4; c++) wr_sum[c] = SUM_W'(item_r.chan[c]);
        end else if (cur_cnt < COUNT_LIMIT) begin
          wr_en  = 1'b1;
          wr_cnt = cur_cnt + 1'b1;
          for (int c = 0; c < 4; c++) wr_sum[c] = rd_sum_r[c] + SUM_W'(item_r.chan[c]);
        end
      end
      B_SCAN:  rd_addr = scan_ctr_r[BUCKET_W-1:0];
      default: rd_addr = best_r;
    endcase
  end

  // Memory ports: one write, one registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[item_r.bucket] <= wr_cnt;
      sum_mem[item_r.bucket] <= wr_sum;
    end
    rd_cnt_r <= cnt_mem[rd_addr];
    rd_sum_r <= sum_mem[rd_addr];
  end

  // Control registers: state, valid bits, scan and divider counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      scan_ctr_r  <= '0;
      cmp_en_r    <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= valid_r[rd_addr];
      if (wr_en) valid_r[item_r.bucket] <= 1'b1;
      cmp_en_r <= (state_r == B_SCAN) && (scan_ctr_r != (BUCKET_W+1)'(BUCKETS));
      if (state_r == B_SCAN) begin
        if (scan_ctr_r != (BUCKET_W+1)'(BUCKETS)) scan_ctr_r <= scan_ctr_r + 1'b1;
      end else begin
        scan_ctr_r <= '0;
      end
      step_r <= (state_r == B_DIV) ? step_r + 1'b1 : '0;
      if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      if (state_r == B_OUT && !out_valid_r) begin
        out_valid_r <= 1'b1;
        valid_r     <= '0;
      end
    end
  end

  // Pixel capture and winner tracking; strict compare keeps the lowest index.
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_item;
    cmp_addr_r <= scan_ctr_r[BUCKET_W-1:0];
    if (state_r == B_UPDATE) begin
      best_r     <= '0;
      best_cnt_r <= '0;
    end else if (cmp_en_r && eff_cnt > best_cnt_r) begin
      best_r     <= cmp_addr_r;
      best_cnt_r <= eff_cnt;
    end
  end

  // Four restoring dividers: (sum + count/2) / count, one bit a cycle.
  always_ff @(posedge clk) begin
    if (state_r == B_LOAD) begin
      for (int c = 0; c < 4; c++) begin
        rem_r[c] <= '0;
        quo_r[c] <= NUM_W'(rd_sum_r[c]) + NUM_W'(best_cnt_r >> 1);
      end
    end else if (state_r == B_DIV) begin
      for (int c = 0; c < 4; c++) begin
        if ({rem_r[c], quo_r[c][NUM_W-1]} >= {1'b0, best_cnt_r}) begin
          rem_r[c] <= CNT_W'({rem_r[c], quo_r[c][NUM_W-1]} - {1'b0, best_cnt_r});
          quo_r[c] <= {quo_r[c][NUM_W-2:0], 1'b1};
        end else begin
          rem_r[c] <= CNT_W'({rem_r[c], quo_r[c][NUM_W-1]});
          quo_r[c] <= {quo_r[c][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // Saturate quotients to the channel range.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      avg[c] = (quo_r[c] > NUM_W'(255)) ? 8'hFF : quo_r[c][CH_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state_r == B_OUT && !out_valid_r) begin
      out_r.red_out        <= avg[3];
      out_r.green_out      <= avg[2];
      out_r.blue_out       <= avg[1];
      out_r.alpha_out      <= avg[0];
      out_r.winning_bucket <= best_r;
      out_r.winning_count  <= best_cnt_r;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/oil_paint_window_mode.sv =====
// ----------------------------------------------------------------------------
// oil_paint_window_mode
// Most frequent intensity bucket of one window and its averaged color.
// ----------------------------------------------------------------------------
// Pixels of one window are pushed in turn; the front classifies each one into
// an intensity bucket and queues it, and the back updates the bucket count and
// channel sums with one read-modify-write per pixel: the histogram is read in
// the idle state and written in the update state. On the last pixel the back
// scans all 256 buckets, reads the winning sums, and runs four bit-serial
// dividers. The result waits in an output register.
module oil_paint_window_mode #(
  parameter int QUEUE_DEPTH = owpm_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  owpm_pkg::in_item_t          in_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output owpm_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [owpm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [owpm_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [owpm_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import owpm_pkg::*;

  logic [7:0] smooth_r;
  logic       q_empty;
  logic       q_pop;
  pix_item_t  q_item;

  // Configuration register write and read back.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_SMOOTHNESS) ? CFG_DW'(smooth_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= SMOOTH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[CFG_AW-1] == REG_SMOOTHNESS) begin
      smooth_r <= cfg_pwdata[7:0];
    end
  end

  owpm_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .smoothness (smooth_r),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .q_pop      (q_pop),
    .q_empty    (q_empty),
    .q_item     (q_item)
  );

  owpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
